// ===== rtl/trs_pkg.sv =====
// Shared constants, types and helper functions for the TRS matrix builder.
package trs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TRIG_STEPS = 16;
    localparam int CORDIC_MAX = 24;
    localparam int NSTEPS     = (TRIG_STEPS > CORDIC_MAX) ? CORDIC_MAX : TRIG_STEPS;
    localparam int CW         = 34;
    localparam int TW         = FRAC_BITS + 4;
    // Multiplier operand width: covers the gains and every trig-derived term.
    localparam int OW         = (FRAC_BITS + 3 > 24) ? FRAC_BITS + 3 : 24;
    localparam int PW         = 2 * OW;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [TW-1:0] trig_t;
    typedef logic [1:0] quad_t;

    // State handed from one CORDIC cell to the next, three angles in parallel.
    typedef struct packed {
        cval_t [2:0] x;
        cval_t [2:0] y;
        cval_t [2:0] z;
        quad_t [2:0] q;
    } cordic_t;

    typedef struct packed {
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
        logic [23:0] gx;
        logic [23:0] gy;
        logic [23:0] gz;
    } side_t;

    function automatic cval_t atan_val(input int i);
        cval_t t;
        case (i)
            0: t = 34'sd536870912;  1: t = 34'sd316933406;
            2: t = 34'sd167458907;  3: t = 34'sd85004756;
            4: t = 34'sd42667331;   5: t = 34'sd21354465;
            6: t = 34'sd10679838;   7: t = 34'sd5340245;
            8: t = 34'sd2670163;    9: t = 34'sd1335087;
            10: t = 34'sd667544;    11: t = 34'sd333772;
            12: t = 34'sd166886;    13: t = 34'sd83443;
            14: t = 34'sd41722;     15: t = 34'sd20861;
            16: t = 34'sd10430;     17: t = 34'sd5215;
            18: t = 34'sd2608;      19: t = 34'sd1304;
            20: t = 34'sd652;       21: t = 34'sd326;
            22: t = 34'sd163;       default: t = 34'sd81;
        endcase
        return t;
    endfunction

    // Round a product of two FRAC_BITS values back to FRAC_BITS.
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (PW'(1) <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
        logic signed [23:0] r;
        if (v > PW'(OUT_MAX)) begin
            r = OUT_MAX;
        end else if (v < PW'(OUT_MIN)) begin
            r = OUT_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/trs_matrix_from_euler_angles_core.sv =====
// Top level: CORDIC cell chain, product pipeline and output register.
// Throughput: one transfer per cycle; a chain of CORDIC cells (one per step)
// and a five-stage multiply pipeline each take a new item every cycle.
// The whole pipe advances together and holds while a result is not taken.
// Reset: synchronous active-low aresetn clears all valid bits; data is not reset.
module trs_matrix_from_euler_angles_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // move_x[31:0], move_y[63:32], move_z[95:64], angle_x[111:96],
    // angle_y[127:112], angle_z[143:128], gain_x[167:144], gain_y[191:168],
    // gain_z[215:192]
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00..m22 at [23:0]..[215:192], t_x[247:216], t_y[279:248], t_z[311:280]
    output logic [311:0] m_axis_tdata
);
    import trs_pkg::*;

    localparam int NP = 5;

    logic    adv;
    cordic_t cc [NSTEPS+1];
    side_t   cs [NSTEPS+1];
    logic    cv [NSTEPS+1];

    // Stall everything when the output register is full and not taken.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb begin
        cc[0] = '0;
        for (int k = 0; k < 3; k++) begin
            cc[0].q[k] = s_axis_tdata[96+16*k+14 +: 2];
            cc[0].z[k] = cval_t'({s_axis_tdata[96+16*k +: 14], 16'b0});
            cc[0].x[k] = CORDIC_K;
            cc[0].y[k] = '0;
        end
        cs[0] = '{mx: s_axis_tdata[31:0], my: s_axis_tdata[63:32],
                  mz: s_axis_tdata[95:64], gx: s_axis_tdata[167:144],
                  gy: s_axis_tdata[191:168], gz: s_axis_tdata[215:192]};
        cv[0] = s_axis_tvalid;
    end

    for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
        trs_cordic_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .adv(adv), .step(5'(i)),
            .vld_in(cv[i]), .c_in(cc[i]), .s_in(cs[i]),
            .vld_out(cv[i+1]), .c_out(cc[i+1]), .s_out(cs[i+1])
        );
    end

    // Quadrant fold and rounding of the Q30 results.
    trig_t sn [3], cn [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cval_t c, s;
            unique case (cc[NSTEPS].q[k])
                2'd0: begin c = cc[NSTEPS].x[k];  s = cc[NSTEPS].y[k];  end
                2'd1: begin c = -cc[NSTEPS].y[k]; s = cc[NSTEPS].x[k];  end
                2'd2: begin c = -cc[NSTEPS].x[k]; s = -cc[NSTEPS].y[k]; end
                default: begin c = cc[NSTEPS].y[k]; s = -cc[NSTEPS].x[k]; end
            endcase
            cn[k] = TW'((c + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
            sn[k] = TW'((s + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
        end
    end

    typedef logic signed [PW-1:0] w_t;
    // Stage 1: trig registered.
    w_t sx1_reg, cx1_reg, sy1_reg, cy1_reg, sz1_reg, cz1_reg;
    // Stage 2: first products.
    w_t cysz_reg, sysz_reg, cycz_reg, sycz_reg, czsx_reg, czcx_reg;
    w_t sycx_reg, sysx_reg, cycx_reg, cysx_reg, nsz2_reg, sx2_reg, cx2_reg;
    // Stage 3: rotation entries.
    w_t r_reg [9];
    // Stage 4: scaled.
    w_t g_reg [9];
    side_t sd_reg [NP];
    logic  v_reg [NP];
    logic [23:0] m_reg [9];

    // Every operand fits in OW bits; multiply at that width and round.
    function automatic w_t mr(input w_t a, input w_t b);
        logic signed [OW-1:0] an, bn;
        an = a[OW-1:0];
        bn = b[OW-1:0];
        return rnd(w_t'(an) * w_t'(bn));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NP; p++) v_reg[p] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= cv[NSTEPS];
            for (int p = 1; p < NP; p++) v_reg[p] <= v_reg[p-1];
        end
        if (adv) begin
            sd_reg[0] <= cs[NSTEPS];
            for (int p = 1; p < NP; p++) sd_reg[p] <= sd_reg[p-1];
            sx1_reg <= w_t'(sn[0]); cx1_reg <= w_t'(cn[0]);
            sy1_reg <= w_t'(sn[1]); cy1_reg <= w_t'(cn[1]);
            sz1_reg <= w_t'(sn[2]); cz1_reg <= w_t'(cn[2]);
            cysz_reg <= mr(cy1_reg, sz1_reg); sysz_reg <= mr(sy1_reg, sz1_reg);
            cycz_reg <= mr(cy1_reg, cz1_reg); sycz_reg <= mr(sy1_reg, cz1_reg);
            czsx_reg <= mr(cz1_reg, sx1_reg); czcx_reg <= mr(cz1_reg, cx1_reg);
            sycx_reg <= mr(sy1_reg, cx1_reg); sysx_reg <= mr(sy1_reg, sx1_reg);
            cycx_reg <= mr(cy1_reg, cx1_reg); cysx_reg <= mr(cy1_reg, sx1_reg);
            nsz2_reg <= -sz1_reg; sx2_reg <= sx1_reg; cx2_reg <= cx1_reg;
            r_reg[0] <= cycz_reg;
            r_reg[1] <= mr(cysz_reg, sx2_reg) - sycx_reg;
            r_reg[2] <= mr(cysz_reg, cx2_reg) + sysx_reg;
            r_reg[3] <= sycz_reg;
            r_reg[4] <= mr(sysz_reg, sx2_reg) + cycx_reg;
            r_reg[5] <= mr(sysz_reg, cx2_reg) - cysx_reg;
            r_reg[6] <= nsz2_reg;
            r_reg[7] <= czsx_reg;
            r_reg[8] <= czcx_reg;
            for (int e = 0; e < 9; e++) begin
                case (e % 3)
                    0: g_reg[e] <= mr(r_reg[e], w_t'($signed(sd_reg[2].gx)));
                    1: g_reg[e] <= mr(r_reg[e], w_t'($signed(sd_reg[2].gy)));
                    default: g_reg[e] <= mr(r_reg[e], w_t'($signed(sd_reg[2].gz)));
                endcase
            end
            for (int e = 0; e < 9; e++) m_reg[e] <= sat24(g_reg[e]);
        end
    end

    assign m_axis_tvalid = v_reg[NP-1];
    always_comb begin
        for (int e = 0; e < 9; e++) m_axis_tdata[24*e +: 24] = m_reg[e];
        m_axis_tdata[247:216] = sd_reg[NP-1].mx;
        m_axis_tdata[279:248] = sd_reg[NP-1].my;
        m_axis_tdata[311:280] = sd_reg[NP-1].mz;
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output slot");
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
`endif
endmodule

// ===== rtl/trs_cordic_cell.sv =====
// One CORDIC micro-rotation stage for three angles, with side data carried along.
module trs_cordic_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [4:0]        step,
    input  logic              vld_in,
    input  trs_pkg::cordic_t  c_in,
    input  trs_pkg::side_t    s_in,
    output logic              vld_out,
    output trs_pkg::cordic_t  c_out,
    output trs_pkg::side_t    s_out
);
    import trs_pkg::*;

    logic    vld_reg;
    cordic_t c_reg, c_next;
    side_t   s_reg;
    cval_t   atn;

    assign atn = atan_val(int'(step));

    always_comb begin
        c_next = c_in;
        for (int k = 0; k < 3; k++) begin
            if (!c_in.z[k][CW-1]) begin
                c_next.x[k] = c_in.x[k] - (c_in.y[k] >>> step);
                c_next.y[k] = c_in.y[k] + (c_in.x[k] >>> step);
                c_next.z[k] = c_in.z[k] - atn;
            end else begin
                c_next.x[k] = c_in.x[k] + (c_in.y[k] >>> step);
                c_next.y[k] = c_in.y[k] - (c_in.x[k] >>> step);
                c_next.z[k] = c_in.z[k] + atn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= vld_in;
        end
        if (adv) begin
            c_reg <= c_next;
            s_reg <= s_in;
        end
    end

    assign vld_out = vld_reg;
    assign c_out   = c_reg;
    assign s_out   = s_reg;
endmodule

// ===== verif/trs_matrix_from_euler_angles_core_test.sv =====
// Self-checking testbench for the TRS model-matrix builder core.
`timescale 1ns / 1ps

module trs_matrix_from_euler_angles_core_test;
    import trs_pkg::*;

    localparam int LATENCY   = NSTEPS + 5;
    localparam int N_RANDOM  = 1330;
    localparam int LONG_HOLD = 60;
    localparam int MAX_ERRS  = 10;

    typedef struct packed {
        logic signed [23:0] gz;
        logic signed [23:0] gy;
        logic signed [23:0] gx;
        logic [15:0]        az;
        logic [15:0]        ay;
        logic [15:0]        ax;
        logic signed [31:0] mz;
        logic signed [31:0] my;
        logic signed [31:0] mx;
    } pose_t;

    typedef struct packed {
        logic signed [31:0] tz;
        logic signed [31:0] ty;
        logic signed [31:0] tx;
        logic signed [23:0] m22;
        logic signed [23:0] m21;
        logic signed [23:0] m20;
        logic signed [23:0] m12;
        logic signed [23:0] m11;
        logic signed [23:0] m10;
        logic signed [23:0] m02;
        logic signed [23:0] m01;
        logic signed [23:0] m00;
    } matrix_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [311:0] m_axis_tdata;

    pose_t   pose_queue[$];
    matrix_t matrix_queue[$];
    int      mismatches;
    bit      stim_done;
    bit      src_idle_ok;   // random gaps on the sender side
    bit      sink_idle_ok;  // random stalls on the receiver side
    bit      hold_sink;     // long receiver hold-off
    bit      pause_src;     // sender waits until drained
    int      src_gap;
    int      sink_gap;
    int      hold_cnt;

    trs_matrix_from_euler_angles_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Transform predictor
    // ---------------------------------------------------------------
    function automatic longint flr_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_frac(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Sine and cosine of a binary angle, FRAC_BITS fraction bits.
    function automatic void trig(input logic [15:0] ang, output longint sn,
                                 output longint cs);
        logic [31:0] wide;
        logic [1:0]  quad;
        longint      x, y, z, nx, ny, c, s;
        wide = {ang, 16'h0000};
        quad = wide[31:30];
        z = longint'(wide[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < NSTEPS; i++) begin
            if (z >= 0) begin
                nx = x - flr_shr(y, i);
                ny = y + flr_shr(x, i);
                z  = z - longint'(atan_val(i));
            end else begin
                nx = x + flr_shr(y, i);
                ny = y - flr_shr(x, i);
                z  = z + longint'(atan_val(i));
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cs = round_frac(c, 30 - FRAC_BITS);
        sn = round_frac(s, 30 - FRAC_BITS);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_frac(a * b, FRAC_BITS);
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607) begin
            return 24'sh7FFFFF;
        end
        if (v < -8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic matrix_t build_matrix(pose_t p);
        matrix_t m;
        longint  sx, cx, sy, cy, sz, cz, gx, gy, gz, cysz, sysz;
        trig(p.ax, sx, cx);
        trig(p.ay, sy, cy);
        trig(p.az, sz, cz);
        gx = p.gx;
        gy = p.gy;
        gz = p.gz;
        cysz = qmul(cy, sz);
        sysz = qmul(sy, sz);
        m.m00 = clamp24(qmul(qmul(cy, cz), gx));
        m.m01 = clamp24(qmul(qmul(cysz, sx) - qmul(sy, cx), gy));
        m.m02 = clamp24(qmul(qmul(cysz, cx) + qmul(sy, sx), gz));
        m.m10 = clamp24(qmul(qmul(sy, cz), gx));
        m.m11 = clamp24(qmul(qmul(sysz, sx) + qmul(cy, cx), gy));
        m.m12 = clamp24(qmul(qmul(sysz, cx) - qmul(cy, sx), gz));
        m.m20 = clamp24(qmul(-sz, gx));
        m.m21 = clamp24(qmul(qmul(cz, sx), gy));
        m.m22 = clamp24(qmul(qmul(cz, cx), gz));
        m.tx = p.mx;
        m.ty = p.my;
        m.tz = p.mz;
        return m;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic pose_t rand_pose();
        pose_t p;
        p.mx = $urandom;
        p.my = $urandom;
        p.mz = $urandom;
        p.ax = 16'($urandom);
        p.ay = 16'($urandom);
        p.az = 16'($urandom);
        // Mostly moderate gains, sometimes full range to hit saturation.
        if ($urandom_range(3) == 0) begin
            p.gx = 24'($urandom);
            p.gy = 24'($urandom);
            p.gz = 24'($urandom);
        end else begin
            p.gx = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
            p.gy = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
            p.gz = $signed(24'($urandom_range(0, 2 ** 20))) - 24'sd524288;
        end
        // Land on a quadrant boundary now and then.
        if ($urandom_range(7) == 0) begin
            p.ax = 16'($urandom_range(3)) << 14;
        end
        return p;
    endfunction

    function automatic pose_t make_pose(logic [31:0] m, logic [15:0] a0, logic [15:0] a1,
                                        logic [15:0] a2, logic [23:0] g);
        pose_t p;
        p.mx = m;
        p.my = ~m;
        p.mz = m ^ 32'h5A5A_A5A5;
        p.ax = a0;
        p.ay = a1;
        p.az = a2;
        p.gx = g;
        p.gy = g;
        p.gz = g;
        return p;
    endfunction

    // Directed set: zero angle, quadrant edges, extreme gains and moves.
    task automatic add_directed();
        pose_queue.push_back(make_pose(32'h0, 16'h0, 16'h0, 16'h0, 24'h010000));
        pose_queue.push_back(make_pose(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF));
        pose_queue.push_back(make_pose(32'h8000_0000, 16'h4000, 16'h4000, 16'h4000, 24'h800000));
        pose_queue.push_back(make_pose(32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 24'hFFFFFF));
        pose_queue.push_back(make_pose(32'h0001_0000, 16'hC000, 16'hC000, 16'hC000, 24'hFF0000));
        pose_queue.push_back(make_pose(32'h1234_5678, 16'h2000, 16'h6000, 16'hA000, 24'h7FFFFF));
        pose_queue.push_back(make_pose(32'hDEAD_BEEF, 16'hE000, 16'h2000, 16'h6000, 24'h800000));
        pose_queue.push_back(make_pose(32'h0, 16'h0001, 16'h3FFF, 16'h7FFF, 24'h000000));
        pose_queue.push_back(make_pose(32'h0, 16'h4001, 16'hBFFF, 16'hC001, 24'h000001));
        pose_queue.push_back(make_pose(32'hAAAA_AAAA, 16'h5555, 16'hAAAA, 16'h5555, 24'h555555));
        pose_queue.push_back(make_pose(32'h5555_5555, 16'hAAAA, 16'h5555, 16'hAAAA, 24'hAAAAAA));
        pose_queue.push_back(make_pose(32'h0, 16'h1000, 16'h1000, 16'h1000, 24'h400000));
    endtask

    // ---------------------------------------------------------------
    // Driver: present the head of pose_queue, advance on transfer
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            logic offer;
            if (s_axis_tvalid && s_axis_tready) begin
                void'(pose_queue.pop_front());
            end
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
            end
            offer = (pose_queue.size() > 0) && !pause_src && (src_gap == 0);
            if (offer && src_idle_ok && !(s_axis_tvalid && !s_axis_tready)
                    && $urandom_range(9) == 0) begin
                src_gap <= $urandom_range(0, 2);
                offer = 1'b0;
            end
            s_axis_tvalid <= offer;
            if (offer) begin
                s_axis_tdata <= pose_queue[0];
            end
        end
    end

    // Predict at transfer time.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            matrix_queue.push_back(build_matrix(pose_t'(s_axis_tdata)));
        end
    end

    // ---------------------------------------------------------------
    // Receiver ready: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
        end else if (hold_sink) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
        end else if (sink_gap > 0) begin
            sink_gap      <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_ok && $urandom_range(7) == 0) begin
            sink_gap      <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            matrix_t got, want;
            got = m_axis_tdata;
            if (matrix_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_ERRS) begin
                    $display("unexpected result %h", got);
                end
            end else begin
                want = matrix_queue.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_ERRS) begin
                        $display("matrix mismatch at %0t", $realtime);
                        $display("  m00 %h/%h m01 %h/%h m02 %h/%h", want.m00, got.m00,
                                 want.m01, got.m01, want.m02, got.m02);
                        $display("  m10 %h/%h m11 %h/%h m12 %h/%h", want.m10, got.m10,
                                 want.m11, got.m11, want.m12, got.m12);
                        $display("  m20 %h/%h m21 %h/%h m22 %h/%h", want.m20, got.m20,
                                 want.m21, got.m21, want.m22, got.m22);
                        $display("  t %h %h %h / %h %h %h", want.tx, want.ty, want.tz,
                                 got.tx, got.ty, got.tz);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        stim_done     = 1'b0;
        src_idle_ok   = 1'b1;
        sink_idle_ok  = 1'b1;
        hold_sink     = 1'b0;
        pause_src     = 1'b0;
        src_gap       = 0;
        sink_gap      = 0;
        add_directed();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Drain the directed set, then pause the sender until all results are back.
        wait (pose_queue.size() == 0);
        pause_src = 1'b1;
        wait (matrix_queue.size() == 0);
        @(posedge aclk);

        // Hold the receiver off while the sender keeps offering: the pipe fills.
        for (int i = 0; i < 200; i++) begin
            pose_queue.push_back(rand_pose());
        end
        pause_src = 1'b0;
        hold_sink = 1'b1;
        wait (hold_cnt >= LONG_HOLD);
        hold_sink = 1'b0;

        for (int i = 0; i < N_RANDOM - 400; i++) begin
            pose_queue.push_back(rand_pose());
        end
        wait (pose_queue.size() == 0);

        // Last part runs at full rate with no idling.
        src_idle_ok  = 1'b0;
        sink_idle_ok = 1'b0;
        for (int i = 0; i < 200; i++) begin
            pose_queue.push_back(rand_pose());
        end
        wait (pose_queue.size() == 0);
        wait (matrix_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);

        if (mismatches == 0 && matrix_queue.size() == 0) begin
            $display("trs_matrix_from_euler_angles_core_test: PASS");
        end else begin
            $display("trs_matrix_from_euler_angles_core_test: FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200000;
        $display("trs_matrix_from_euler_angles_core_test: FAIL");
        $finish;
    end

endmodule
